// ----- rtl/kvlp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvlp_pkg: shared types and constants of the key/value line parser
// Character codes, parse modes, result kinds and the result record that the
// parse stage hands to the result queue.
// ---------------------------------------------------------------------------
package kvlp_pkg;

   // Longest name and value, in characters
   localparam int NAME_MAX  = 32;
   localparam int VALUE_MAX = 64;

   localparam int NameCntW  = 6;
   localparam int ValueCntW = 7;
   localparam int LineW     = 16;
   localparam int ByteW     = 8;

   // Result queue
   localparam int QueueDepth = 8;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = QueuePtrW + 1;

   localparam logic [ByteW-1:0] CHAR_EQUALS     = 8'h3D;
   localparam logic [ByteW-1:0] CHAR_HASH       = 8'h23;
   localparam logic [ByteW-1:0] CHAR_CR         = 8'h0D;
   localparam logic [ByteW-1:0] CHAR_LF         = 8'h0A;
   localparam logic [ByteW-1:0] CHAR_UNDERSCORE = 8'h5F;

   typedef enum logic [1:0] {
      MODE_NAME    = 2'd0,
      MODE_VALUE   = 2'd1,
      MODE_COMMENT = 2'd2,
      MODE_HALTED  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_NAME_CHAR    = 3'd0,
      KIND_VALUE_CHAR   = 3'd1,
      KIND_PAIR_DONE    = 3'd2,
      KIND_SYNTAX_ERROR = 3'd3,
      KIND_FINISHED     = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [ByteW-1:0]       char_value;
      logic [LineW-1:0]       line_number;
      logic                   last;
   } result_type;

   // Up to two results come out of one request
   typedef struct packed {
      logic       push0;
      logic       push1;
      result_type res0;
      result_type res1;
   } parse_out_type;

   function automatic logic name_char_ok(input logic [ByteW-1:0] b);
      return (b == CHAR_UNDERSCORE) || (b inside {[8'h61:8'h7A]}) ||
             (b inside {[8'h41:8'h5A]}) || (b inside {[8'h30:8'h39]});
   endfunction

endpackage

// ----- rtl/kvlp_parse.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvlp_parse: request register and parse state machine
// Holds one accepted request, steps the name/value/comment state machine and
// produces up to two results for the queue in the same cycle.
// ---------------------------------------------------------------------------
module kvlp_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic [kvlp_pkg::ByteW-1:0]   data_byte,
   input  logic                         end_of_input,
   output logic                         busy,
   output kvlp_pkg::parse_out_type      parse_out
);
   import kvlp_pkg::*;

   logic                  in_valid_ff;
   logic [ByteW-1:0]      in_byte_ff;
   logic                  in_eoi_ff;

   mode_type              mode_ff, mode_in;
   logic [NameCntW-1:0]   name_cnt_ff, name_cnt_in;
   logic [ValueCntW-1:0]  value_cnt_ff, value_cnt_in;
   logic [LineW-1:0]      line_ff, line_in;
   logic [LineW-1:0]      line_inc;
   logic                  live;

   assign busy     = in_valid_ff;
   assign live     = in_valid_ff && (mode_ff != MODE_HALTED);
   assign line_inc = (line_ff == {LineW{1'b1}}) ? line_ff : line_ff + LineW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= load;
      end
      if (load) begin
         in_byte_ff <= data_byte;
         in_eoi_ff  <= end_of_input;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NAME;
         name_cnt_ff  <= '0;
         value_cnt_ff <= '0;
         line_ff      <= LineW'(1);
      end else begin
         mode_ff      <= mode_in;
         name_cnt_ff  <= name_cnt_in;
         value_cnt_ff <= value_cnt_in;
         line_ff      <= line_in;
      end
   end

   // Next state
   always_comb begin
      mode_in      = mode_ff;
      name_cnt_in  = name_cnt_ff;
      value_cnt_in = value_cnt_ff;
      line_in      = line_ff;
      if (live) begin
         if (in_eoi_ff) begin
            mode_in = MODE_HALTED;
         end else begin
            case (mode_ff)
               MODE_NAME: begin
                  if (in_byte_ff == CHAR_EQUALS) begin
                     if (name_cnt_ff != '0) begin
                        mode_in      = MODE_VALUE;
                        value_cnt_in = '0;
                     end else begin
                        mode_in = MODE_HALTED;
                     end
                  end else if (in_byte_ff == CHAR_HASH) begin
                     mode_in = MODE_COMMENT;
                  end else if (in_byte_ff == CHAR_CR && name_cnt_ff == '0) begin
                     mode_in = MODE_NAME;
                  end else if (in_byte_ff == CHAR_LF && name_cnt_ff == '0) begin
                     line_in = line_inc;
                  end else if (name_char_ok(in_byte_ff) &&
                               name_cnt_ff < NameCntW'(NAME_MAX)) begin
                     name_cnt_in = name_cnt_ff + NameCntW'(1);
                  end else begin
                     mode_in = MODE_HALTED;
                  end
               end
               MODE_VALUE: begin
                  if (in_byte_ff == CHAR_LF) begin
                     mode_in     = MODE_NAME;
                     name_cnt_in = '0;
                     line_in     = line_inc;
                  end else if (in_byte_ff == CHAR_CR) begin
                     mode_in = MODE_VALUE;
                  end else if (value_cnt_ff < ValueCntW'(VALUE_MAX)) begin
                     value_cnt_in = value_cnt_ff + ValueCntW'(1);
                  end else begin
                     mode_in = MODE_HALTED;
                  end
               end
               MODE_COMMENT: begin
                  if (in_byte_ff == CHAR_LF) begin
                     mode_in = MODE_NAME;
                     line_in = line_inc;
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
      end
   end

   // Results
   always_comb begin
      parse_out                  = '0;
      parse_out.res0.line_number = line_ff;
      parse_out.res1.line_number = line_ff;
      parse_out.res0.kind        = KIND_NAME_CHAR;
      parse_out.res1.kind        = KIND_FINISHED;
      parse_out.res1.last        = 1'b1;
      if (live) begin
         if (in_eoi_ff) begin
            parse_out.push0 = 1'b1;
            if (mode_ff == MODE_VALUE) begin
               parse_out.res0.kind = KIND_PAIR_DONE;
               parse_out.push1     = 1'b1;
            end else begin
               parse_out.res0.kind = KIND_FINISHED;
               parse_out.res0.last = 1'b1;
            end
         end else begin
            parse_out.res0.last = 1'b1;
            case (mode_ff)
               MODE_NAME: begin
                  if (in_byte_ff == CHAR_EQUALS) begin
                     if (name_cnt_ff == '0) begin
                        parse_out.push0     = 1'b1;
                        parse_out.res0.kind = KIND_SYNTAX_ERROR;
                     end
                  end else if (in_byte_ff == CHAR_HASH) begin
                     parse_out.push0 = 1'b0;
                  end else if ((in_byte_ff == CHAR_CR || in_byte_ff == CHAR_LF) &&
                               name_cnt_ff == '0) begin
                     parse_out.push0 = 1'b0;
                  end else if (name_char_ok(in_byte_ff) &&
                               name_cnt_ff < NameCntW'(NAME_MAX)) begin
                     parse_out.push0           = 1'b1;
                     parse_out.res0.kind       = KIND_NAME_CHAR;
                     parse_out.res0.char_value = in_byte_ff;
                  end else begin
                     parse_out.push0     = 1'b1;
                     parse_out.res0.kind = KIND_SYNTAX_ERROR;
                  end
               end
               MODE_VALUE: begin
                  if (in_byte_ff == CHAR_LF) begin
                     parse_out.push0     = 1'b1;
                     parse_out.res0.kind = KIND_PAIR_DONE;
                  end else if (in_byte_ff == CHAR_CR) begin
                     parse_out.push0 = 1'b0;
                  end else if (value_cnt_ff < ValueCntW'(VALUE_MAX)) begin
                     parse_out.push0           = 1'b1;
                     parse_out.res0.kind       = KIND_VALUE_CHAR;
                     parse_out.res0.char_value = in_byte_ff;
                  end else begin
                     parse_out.push0     = 1'b1;
                     parse_out.res0.kind = KIND_SYNTAX_ERROR;
                  end
               end
               default: begin
                  parse_out.push0 = 1'b0;
               end
            endcase
         end
      end
   end

   // A halted parser stays silent until reset
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_HALTED) |-> !parse_out.push0)
      else $error("result produced while halted");

   // Once halted, the mode never leaves halted
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_HALTED) |=> (mode_ff == MODE_HALTED))
      else $error("left halted mode without reset");

   // A second result only follows a pair done at end of input
   assert property (@(posedge clock) disable iff (reset)
      parse_out.push1 |-> (parse_out.push0 && in_eoi_ff &&
                           parse_out.res0.kind == KIND_PAIR_DONE))
      else $error("unexpected second result");

endmodule

// ----- rtl/kvlp_rsp_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvlp_rsp_queue: result queue
// Small register queue that takes up to two results a cycle and presents
// one result at a time on the response side.
// ---------------------------------------------------------------------------
module kvlp_rsp_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  kvlp_pkg::parse_out_type         parse_out,
   input  logic                            pop,
   output logic                            not_empty,
   output logic [kvlp_pkg::QueueCntW-1:0]  count,
   output kvlp_pkg::result_type            head
);
   import kvlp_pkg::*;

   result_type             entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic [QueuePtrW-1:0]   wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + QueuePtrW'(1);
   assign not_empty   = (count_ff != '0);
   assign count       = count_ff;
   assign head        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrW'(parse_out.push0) + QueuePtrW'(parse_out.push1);
      rd_ptr_in = rd_ptr_ff + QueuePtrW'(pop);
      count_in  = count_ff + QueueCntW'(parse_out.push0) + QueueCntW'(parse_out.push1)
                  - QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (parse_out.push0) begin
         entry_ff[wr_ptr_ff] <= parse_out.res0;
      end
      if (parse_out.push1) begin
         entry_ff[wr_ptr_next] <= parse_out.res1;
      end
   end

   // Never overfill
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntW'(QueueDepth))
      else $error("result queue overflow");

   // Never pop an empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("result queue underflow");

   // Pointer distance matches the fill count
   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QueuePtrW-1:0])
      else $error("queue pointers disagree with count");

endmodule

// ----- rtl/key_value_line_parser_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_value_line_parser_core: streaming parser for name=value text lines
// Takes one text byte per request, streams out accepted name and value
// characters, pair-done events and a final finished or syntax-error result.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  --------  ---------  ---------------------------------------------------
//  req_*     in         tdata = data_byte, tlast = end_of_input
//  rsp_*     out        tdata = char_value, line_number; tuser = kind;
//                       tlast = last result of its request
//
//  One request is taken per cycle while req_tready is high; each request
//  leaves the request register in the cycle after acceptance and its results
//  enter the result queue then. A request yields at most two results (pair
//  done plus finished); req_tready is set by free room in the eight-entry
//  result queue, counting the request still held in the request register;
//  rsp_tready back-pressure fills the queue and then holds requests off.
//  Synchronous active-high reset returns to name mode at line one with an
//  empty queue. After a syntax error or end of input the parser halts:
//  requests are still taken but dropped until the next reset.
// ---------------------------------------------------------------------------
module key_value_line_parser_core (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] data_byte
   input  logic         req_tlast,    // end_of_input

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,    // [7:0] char_value, [23:8] line_number
   output logic [2:0]   rsp_tuser,    // [2:0] kind
   output logic         rsp_tlast     // last result of the request
);
   import kvlp_pkg::*;

   logic                  req_accept;
   logic                  rsp_accept;
   logic                  held_busy;
   parse_out_type         parse_out;
   result_type            head;
   logic [QueueCntW-1:0]  q_count;
   logic [QueueCntW:0]    committed;

   // Room for the held request and a new one, two results each
   assign committed  = (QueueCntW+1)'(q_count) +
                       (held_busy ? (QueueCntW+1)'(2) : '0);
   assign req_tready = (committed <= (QueueCntW+1)'(QueueDepth - 2));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // Hold the request and step the parser
   kvlp_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .load         (req_accept),
      .data_byte    (req_tdata),
      .end_of_input (req_tlast),
      .busy         (held_busy),
      .parse_out    (parse_out)
   );

   // Queue results and advance on each response handshake
   kvlp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .parse_out (parse_out),
      .pop       (rsp_accept),
      .not_empty (rsp_tvalid),
      .count     (q_count),
      .head      (head)
   );

   assign rsp_tdata = {head.line_number, head.char_value};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   // Queue can always absorb what the parser produces
   assert property (@(posedge clock) disable iff (reset)
      (parse_out.push0 || parse_out.push1) |->
         ((QueueCntW+1)'(q_count) + (QueueCntW+1)'(2) <= (QueueCntW+1)'(QueueDepth)))
      else $error("parser output would overflow the queue");

   // Character kinds carry a character, all others carry zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && head.kind != KIND_NAME_CHAR && head.kind != KIND_VALUE_CHAR)
         |-> (head.char_value == '0))
      else $error("non-character result with non-zero character");

   // Terminal results always close their request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (head.kind == KIND_FINISHED || head.kind == KIND_SYNTAX_ERROR))
         |-> head.last)
      else $error("terminal result without last");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for key_value_line_parser_core
// Feeds one long text stream of name=value lines, comments and blank lines
// under changing idle and stall patterns, then ends the stream in one
// randomly chosen way that halts the parser. A scoreboard predicts every
// result and checks the result channel.
// ---------------------------------------------------------------------------
module tb_top;
   import kvlp_pkg::*;

   // Shapes of idling on the two channels
   typedef enum int {
      PHASE_CLEAR,
      PHASE_SENDER_IDLE,
      PHASE_RECEIVER_STALL,
      PHASE_BOTH
   } idle_phase_type;

   // Ways in which the stream is brought to its halt
   typedef enum int {
      END_VALUE_EOI,
      END_NAME_EOI,
      END_COMMENT_EOI,
      END_EMPTY_EOI,
      END_BAD_BYTE,
      END_EMPTY_NAME,
      END_LONG_NAME,
      END_LONG_VALUE
   } end_case_type;

   // Predicts the parser's results and checks them in order of arrival
   class line_parse_scoreboard;
      mode_type             mode;
      logic [NameCntW-1:0]  name_count;
      logic [ValueCntW-1:0] value_count;
      logic [LineW-1:0]     line_count;
      result_type           pending_results[$];
      result_type           step_buf[2];
      int                   step_n;
      int                   mismatches;

      function new();
         mode        = MODE_NAME;
         name_count  = '0;
         value_count = '0;
         line_count  = 16'd1;
         mismatches  = 0;
      endfunction

      function bit is_name_byte(logic [7:0] b);
         return (b == CHAR_UNDERSCORE) || (b >= "a" && b <= "z") ||
                (b >= "A" && b <= "Z") || (b >= "0" && b <= "9");
      endfunction

      function void bump_line();
         if (line_count != 16'hFFFF)
            line_count++;
      endfunction

      function void add_result(kind_type k, logic [7:0] ch);
         step_buf[step_n].kind        = k;
         step_buf[step_n].char_value  = ch;
         step_buf[step_n].line_number = line_count;
         step_buf[step_n].last        = 1'b0;
         step_n++;
      endfunction

      // Advance the parse state by one accepted request
      function void note_request(logic [7:0] b, logic eoi);
         step_n = 0;
         if (mode == MODE_HALTED)
            return;
         if (eoi) begin
            if (mode == MODE_VALUE)
               add_result(KIND_PAIR_DONE, 8'h00);
            add_result(KIND_FINISHED, 8'h00);
            mode = MODE_HALTED;
         end else if (mode == MODE_NAME) begin
            if (b == CHAR_EQUALS) begin
               if (name_count != 0) begin
                  mode        = MODE_VALUE;
                  value_count = '0;
               end else begin
                  add_result(KIND_SYNTAX_ERROR, 8'h00);
                  mode = MODE_HALTED;
               end
            end else if (b == CHAR_HASH) begin
               mode = MODE_COMMENT;
            end else if (b == CHAR_CR && name_count == 0) begin
               // carriage return before a name: skip
            end else if (b == CHAR_LF && name_count == 0) begin
               bump_line();
            end else if (is_name_byte(b) && name_count < NAME_MAX) begin
               name_count++;
               add_result(KIND_NAME_CHAR, b);
            end else begin
               add_result(KIND_SYNTAX_ERROR, 8'h00);
               mode = MODE_HALTED;
            end
         end else if (mode == MODE_VALUE) begin
            if (b == CHAR_LF) begin
               add_result(KIND_PAIR_DONE, 8'h00);
               mode       = MODE_NAME;
               name_count = '0;
               bump_line();
            end else if (b == CHAR_CR) begin
               // dropped inside a value
            end else if (value_count < VALUE_MAX) begin
               value_count++;
               add_result(KIND_VALUE_CHAR, b);
            end else begin
               add_result(KIND_SYNTAX_ERROR, 8'h00);
               mode = MODE_HALTED;
            end
         end else if (b == CHAR_LF) begin
            mode = MODE_NAME;
            bump_line();
         end
         if (step_n > 0)
            step_buf[step_n-1].last = 1'b1;
         for (int i = 0; i < step_n; i++)
            pending_results.push_back(step_buf[i]);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result: got kind %0d char %02h line %0d last %0d",
                     $time, got.kind, got.char_value, got.line_number, got.last);
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind || got.char_value !== want.char_value ||
             got.line_number !== want.line_number || got.last !== want.last) begin
            mismatches++;
            $display("%0t: mismatch: expected kind %0d char %02h line %0d last %0d,",
                     $time, want.kind, want.char_value, want.line_number, want.last);
            $display("%0t:           got kind %0d char %02h line %0d last %0d",
                     $time, got.kind, got.char_value, got.line_number, got.last);
         end
      endfunction
   endclass

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = 8'h00;   // [7:0] data_byte
   logic         req_tlast  = 1'b0;    // end_of_input
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;            // [7:0] char_value, [23:8] line_number
   logic [2:0]   rsp_tuser;            // [2:0] kind
   logic         rsp_tlast;            // last result of the request

   int unsigned  sender_idle_pct    = 0;
   int unsigned  receiver_stall_pct = 0;
   int unsigned  requests_sent      = 0;
   result_type   observed;
   line_parse_scoreboard board = new();

   key_value_line_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Check a result at every handshake on the result channel, then pick
   // the next cycle's ready at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed.kind        = kind_type'(rsp_tuser);
         observed.char_value  = rsp_tdata[7:0];
         observed.line_number = rsp_tdata[23:8];
         observed.last        = rsp_tlast;
         board.check_result(observed);
      end
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Hold one request on the channel until accepted, with random idle first
   task automatic send_request(input logic [7:0] b, input logic eoi);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoi;
      do
         @(posedge clock);
      while (!req_tready);
      board.note_request(b, eoi);
      requests_sent++;
   endtask

   function automatic logic [7:0] random_name_byte();
      int unsigned r = $urandom_range(62);
      logic [7:0]  pick;
      pick = r[7:0];
      if (r < 26)
         return "a" + pick;
      else if (r < 52)
         return "A" + (pick - 8'd26);
      else if (r < 62)
         return "0" + (pick - 8'd52);
      return CHAR_UNDERSCORE;
   endfunction

   function automatic logic [7:0] random_text_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == CHAR_LF);
      return b;
   endfunction

   task automatic send_name_chars(input int n);
      repeat (n) send_request(random_name_byte(), 1'b0);
   endtask

   // Carriage returns are dropped by the parser, so count only real bytes
   task automatic send_value_chars(input int n);
      int         taken = 0;
      logic [7:0] b;
      while (taken < n) begin
         b = random_text_byte();
         send_request(b, 1'b0);
         if (b != CHAR_CR)
            taken++;
      end
   endtask

   task automatic send_comment_body();
      repeat ($urandom_range(10)) send_request(random_text_byte(), 1'b0);
   endtask

   // A well-formed pair line; now and then the name is split by a comment
   task automatic send_pair_line();
      int name_len  = ($urandom_range(9) == 0) ? NAME_MAX : $urandom_range(1, 8);
      int value_len = ($urandom_range(9) == 0) ? VALUE_MAX : $urandom_range(12);
      int split;
      if ($urandom_range(7) == 0)
         send_request(CHAR_CR, 1'b0);
      if (name_len > 1 && $urandom_range(5) == 0) begin
         split = $urandom_range(1, name_len - 1);
         send_name_chars(split);
         send_request(CHAR_HASH, 1'b0);
         send_comment_body();
         send_request(CHAR_LF, 1'b0);
         send_name_chars(name_len - split);
      end else begin
         send_name_chars(name_len);
      end
      send_request(CHAR_EQUALS, 1'b0);
      send_value_chars(value_len);
      if ($urandom_range(3) == 0)
         send_request(CHAR_CR, 1'b0);
      send_request(CHAR_LF, 1'b0);
   endtask

   task automatic send_random_line();
      int unsigned r = $urandom_range(9);
      if (r < 7) begin
         send_pair_line();
      end else if (r == 7) begin
         send_request(CHAR_HASH, 1'b0);
         send_comment_body();
         send_request(CHAR_LF, 1'b0);
      end else begin
         if ($urandom_range(1))
            send_request(CHAR_CR, 1'b0);
         send_request(CHAR_LF, 1'b0);
      end
   endtask

   task automatic apply_phase(input idle_phase_type p);
      case (p)
         PHASE_CLEAR: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         PHASE_SENDER_IDLE: begin
            sender_idle_pct    = 84;
            receiver_stall_pct = 0;
         end
         PHASE_RECEIVER_STALL: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 84;
         end
         default: begin
            sender_idle_pct    = 26;
            receiver_stall_pct = 26;
         end
      endcase
   endtask

   // Bring the stream to its halt in one of the ways the parser allows
   task automatic end_stream(input end_case_type how);
      logic [7:0] b;
      case (how)
         END_VALUE_EOI: begin
            send_name_chars($urandom_range(1, 4));
            send_request(CHAR_EQUALS, 1'b0);
            send_value_chars($urandom_range(5));
            send_request(8'($urandom_range(255)), 1'b1);
         end
         END_NAME_EOI: begin
            send_name_chars($urandom_range(1, 4));
            send_request(8'($urandom_range(255)), 1'b1);
         end
         END_COMMENT_EOI: begin
            send_request(CHAR_HASH, 1'b0);
            send_comment_body();
            send_request(8'($urandom_range(255)), 1'b1);
         end
         END_EMPTY_EOI: begin
            send_request(8'($urandom_range(255)), 1'b1);
         end
         END_BAD_BYTE: begin
            // partial name, then a byte no name may hold (line ends too)
            send_name_chars($urandom_range(1, 4));
            if ($urandom_range(2) == 0) begin
               b = $urandom_range(1) ? CHAR_CR : CHAR_LF;
            end else begin
               do
                  b = 8'($urandom_range(255));
               while (board.is_name_byte(b) || b == CHAR_EQUALS || b == CHAR_HASH);
            end
            send_request(b, 1'b0);
         end
         END_EMPTY_NAME: begin
            send_request(CHAR_EQUALS, 1'b0);
         end
         END_LONG_NAME: begin
            send_name_chars(NAME_MAX + 1);
         end
         default: begin
            send_name_chars($urandom_range(1, 3));
            send_request(CHAR_EQUALS, 1'b0);
            send_value_chars(VALUE_MAX + 1);
         end
      endcase
   endtask

   initial begin
      logic [7:0]   directed [$];
      end_case_type how;
      int unsigned  phase_target;
      int           left_over;

      // Blank line after a carriage return, a comment, a pair with the name
      // and value byte extremes, a comment splitting a name, an empty value
      directed = '{CHAR_CR, CHAR_LF, CHAR_HASH, 8'hFF, CHAR_LF,
                   "A", "_", "z", "9", CHAR_EQUALS,
                   8'h00, 8'hFF, CHAR_EQUALS, CHAR_HASH, CHAR_CR, CHAR_LF,
                   "a", CHAR_HASH, 8'h7F, CHAR_LF, "Z", "0", CHAR_EQUALS, CHAR_LF};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_request(directed[i], 1'b0);

      // Random lines, cycling through the idle patterns; drain between
      // phases so the sender sits out until every result is back
      for (int p = 0; p < 8; p++) begin
         apply_phase(idle_phase_type'(p % 4));
         phase_target = requests_sent + 160;
         while (requests_sent < phase_target)
            send_random_line();
         req_tvalid <= 1'b0;
         while (board.pending_results.size() != 0)
            @(posedge clock);
      end

      // A few more lines under mixed idling, then the halt
      apply_phase(PHASE_BOTH);
      repeat (6) send_random_line();

      how = end_case_type'($urandom_range(7));
      end_stream(how);

      // Everything after the halt must be swallowed without a result
      repeat (12) send_request(8'($urandom_range(255)), 1'($urandom_range(1)));
      req_tvalid <= 1'b0;

      for (int w = 0; w < 5000 && board.pending_results.size() != 0; w++)
         @(posedge clock);
      repeat (20) @(posedge clock);

      left_over = board.pending_results.size();
      if (left_over != 0) begin
         $display("%0t: %0d expected results never arrived", $time, left_over);
         board.mismatches += left_over;
      end
      if (board.mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
